// ----- src/efrp_pkg.sv -----
// Package for the Ethernet frame receive parser: sizes, byte codes,
// status codes and the result record type. No dependencies.
package efrp_pkg;

    // Frame layout and limits
    localparam int unsigned MAX_FRAME_LEN = 1526;
    localparam int unsigned MIN_FRAME_LEN = 72;
    localparam int unsigned MAX_DATA_LEN  = 1500;
    localparam int unsigned HDR_CRC_LEN   = 26;
    localparam int unsigned POS_W         = 11;
    localparam int unsigned LEN_W         = 11;

    localparam logic [7:0] PRE_BYTE = 8'hAA;
    localparam logic [7:0] SFD_BYTE = 8'hAB;

    localparam logic [POS_W-1:0] POS_SFD      = POS_W'(7);
    localparam logic [POS_W-1:0] POS_SRC_END  = POS_W'(14);
    localparam logic [POS_W-1:0] POS_DST_LAST = POS_W'(19);
    localparam logic [POS_W-1:0] POS_DST_END  = POS_W'(20);
    localparam logic [POS_W-1:0] POS_TYPE_END = POS_W'(22);
    localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_LONG      = 3'd2,
        ST_BAD_PRE   = 3'd3,
        ST_ADDR_MISS = 3'd4
    } t_status;

    // Output queue sizing
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    // Packed result payload, last field in the lowest bits
    typedef struct packed {
        logic [31:0]      trailer_word;
        logic [LEN_W-1:0] payload_length;
        logic [15:0]      frame_type;
        logic [47:0]      dest_mac;
        logic [47:0]      source_mac;
        logic [2:0]       status;
        logic [7:0]       payload_byte;
    } t_fields;

    typedef struct packed {
        logic    result_kind;
        logic    last_of_run;
        t_fields fields;
    } t_result;

endpackage

// ----- src/ethernet_frame_receive_parser_top.sv -----
// Ethernet frame receive parser, top level.
// Depends on efrp_pkg for constants, status codes and the result type.
//
// Usage:
//  - Input stream (i_s_axis_*): one received byte per request, preamble
//    first; tlast marks the final byte of the frame.
//  - Output stream (o_m_axis_*): tuser 0 carries a forwarded payload byte,
//    tuser 1 the end-of-frame verdict with status, header fields, payload
//    length and the raw last four bytes. tlast is set on the final result
//    caused by an input byte.
//  - Station address: written through i_cfg_wr_en / i_cfg_wr_data while
//    the block is idle.
// Timing: each accepted byte is parsed in the cycle it is taken; its
// results are registered in a four-entry output queue and leave it in order.
// One byte per cycle is accepted while the queue has room for two results,
// so with the receiver always ready the block runs at one byte per cycle,
// and the frame's last byte (up to two results) does not stall the input.
// Reset clears the frame state, the station address and the queue.
// When the receiver stalls, results wait in the queue and tready drops
// once fewer than two entries are free.
module ethernet_frame_receive_parser_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tdata: frame_byte[7:0]
    input  logic [7:0]                      i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: payload_byte[7:0], status[10:8], source_mac[58:11],
    // dest_mac[106:59], frame_type[122:107], payload_length[133:123],
    // trailer_word[165:134], zero[167:166]
    output logic [167:0]                    o_m_axis_tdata,
    // tuser: result_kind[0]
    output logic                            o_m_axis_tuser,
    output logic                            o_m_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic                            i_cfg_wr_en,
    input  logic [47:0]                     i_cfg_wr_data
);
    import efrp_pkg::*;

    // Frame state
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_pre_good, n_pre_good;
    logic [47:0]      r_src, n_src;
    logic [47:0]      r_dst, n_dst;
    logic [15:0]      r_type, n_type;
    logic             r_addr_good, n_addr_good;
    logic [7:0]       r_tail [4];
    logic [7:0]       n_tail [4];
    logic [47:0]      r_station_mac;

    // Output queue
    t_result          r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic             in_fire, out_fire;
    logic             push_pay, push_ver;
    logic [QCNT_W-1:0] push_n;
    logic [POS_W:0]   frame_len;
    logic [POS_W:0]   plen_full;
    t_status          ver_status;
    logic [LEN_W-1:0] ver_plen;
    t_result          pay_res, ver_res;
    logic [7:0]       b;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;
    assign b        = i_s_axis_tdata;

    // Room for two results keeps the frame's last byte from stalling
    assign o_s_axis_tready = (r_count <= QCNT_W'(QDEPTH - 2));

    // Header parsing and tail delay
    always_comb begin
        n_pre_good  = r_pre_good;
        n_src       = r_src;
        n_dst       = r_dst;
        n_type      = r_type;
        n_addr_good = r_addr_good;
        if (r_pos < POS_SFD) begin
            if (b != PRE_BYTE) n_pre_good = 1'b0;
        end else if (r_pos == POS_SFD) begin
            if (b != SFD_BYTE) n_pre_good = 1'b0;
        end else if (r_pos < POS_SRC_END) begin
            n_src = {r_src[39:0], b};
        end else if (r_pos < POS_DST_END) begin
            n_dst = {r_dst[39:0], b};
            if (r_pos == POS_DST_LAST) n_addr_good = ({r_dst[39:0], b} == r_station_mac);
        end else if (r_pos < POS_TYPE_END) begin
            n_type = {r_type[7:0], b};
        end
        n_tail[0] = b;
        n_tail[1] = r_tail[0];
        n_tail[2] = r_tail[1];
        n_tail[3] = r_tail[2];
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + POS_W'(1);
    end

    // Payload forwarding decision: byte leaving the delay
    always_comb begin
        push_pay = (r_pos >= POS_W'(HDR_CRC_LEN)) && (r_pos < POS_W'(MAX_FRAME_LEN))
                && ((r_pos - POS_W'(HDR_CRC_LEN)) < POS_W'(MAX_DATA_LEN))
                && r_pre_good && r_addr_good;
        push_ver = i_s_axis_tlast;
        push_n   = QCNT_W'(push_pay) + QCNT_W'(push_ver);

        pay_res                     = '0;
        pay_res.result_kind         = KIND_PAYLOAD;
        pay_res.last_of_run         = !i_s_axis_tlast;
        pay_res.fields.payload_byte = r_tail[3];
    end

    // Verdict: status priority short, long, preamble, address
    always_comb begin
        frame_len = {1'b0, r_pos} + (POS_W+1)'(1);
        plen_full = frame_len - (POS_W+1)'(HDR_CRC_LEN);
        if (frame_len < (POS_W+1)'(MIN_FRAME_LEN))      ver_status = ST_SHORT;
        else if (frame_len > (POS_W+1)'(MAX_FRAME_LEN)) ver_status = ST_LONG;
        else if (!n_pre_good)                           ver_status = ST_BAD_PRE;
        else if (!n_addr_good)                          ver_status = ST_ADDR_MISS;
        else                                            ver_status = ST_OK;

        if (frame_len < (POS_W+1)'(HDR_CRC_LEN))        ver_plen = '0;
        else if (plen_full > (POS_W+1)'(MAX_DATA_LEN))  ver_plen = LEN_W'(MAX_DATA_LEN);
        else                                            ver_plen = plen_full[LEN_W-1:0];

        ver_res                       = '0;
        ver_res.result_kind           = KIND_VERDICT;
        ver_res.last_of_run           = 1'b1;
        ver_res.fields.status         = ver_status;
        ver_res.fields.source_mac     = n_src;
        ver_res.fields.dest_mac       = n_dst;
        ver_res.fields.frame_type     = n_type;
        ver_res.fields.payload_length = ver_plen;
        ver_res.fields.trailer_word   = {n_tail[3], n_tail[2], n_tail[1], n_tail[0]};
    end

    // Frame state and station address registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_pre_good    <= 1'b1;
            r_src         <= '0;
            r_dst         <= '0;
            r_type        <= '0;
            r_addr_good   <= 1'b0;
            r_tail        <= '{default: '0};
            r_station_mac <= '0;
        end else begin
            if (i_cfg_wr_en) r_station_mac <= i_cfg_wr_data;
            if (in_fire) begin
                if (i_s_axis_tlast) begin
                    r_pos       <= '0;
                    r_pre_good  <= 1'b1;
                    r_src       <= '0;
                    r_dst       <= '0;
                    r_type      <= '0;
                    r_addr_good <= 1'b0;
                    r_tail      <= '{default: '0};
                end else begin
                    r_pos       <= n_pos;
                    r_pre_good  <= n_pre_good;
                    r_src       <= n_src;
                    r_dst       <= n_dst;
                    r_type      <= n_type;
                    r_addr_good <= n_addr_good;
                    r_tail      <= n_tail;
                end
            end
        end
    end

    // Queue entries: payload result first, verdict after it
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (push_pay) r_q[r_wr_ptr] <= pay_res;
            if (push_ver) r_q[r_wr_ptr + QPTR_W'(push_pay)] <= ver_res;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_fire) r_wr_ptr <= r_wr_ptr + push_n[QPTR_W-1:0];
            if (out_fire) r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            r_count <= r_count + (in_fire ? push_n : '0) - QCNT_W'(out_fire);
        end
    end

    // Output channel from the queue head
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {2'b00, r_q[r_rd_ptr].fields};
    assign o_m_axis_tuser  = r_q[r_rd_ptr].result_kind;
    assign o_m_axis_tlast  = r_q[r_rd_ptr].last_of_run;

endmodule

// ----- tb/sv/efrp_rx_checker.sv -----
// Scoreboard for the Ethernet frame receive parser: watches the byte stream,
// the result stream and the station address port, predicts and compares.
// Depends on efrp_pkg for sizes, byte codes, status codes and result types.
module efrp_rx_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // byte stream into the block
    input  logic [7:0]   i_byte_tdata,
    input  logic         i_byte_tlast,
    input  logic         i_byte_tvalid,
    input  logic         i_byte_tready,
    // result stream out of the block
    input  logic [167:0] i_res_tdata,
    input  logic         i_res_tuser,
    input  logic         i_res_tlast,
    input  logic         i_res_tvalid,
    input  logic         i_res_tready,
    // station address port
    input  logic         i_cfg_wr_en,
    input  logic [47:0]  i_cfg_wr_data,
    output int           o_pending,
    output int           o_mismatches
);
    import efrp_pkg::*;

    localparam int FIELDS_W = $bits(t_fields);

    // Shadow of the parser state
    logic [47:0]      station_addr;
    logic [POS_W-1:0] pos;
    logic             pre_ok;
    logic             addr_ok;
    logic [47:0]      src_sr;
    logic [47:0]      dst_sr;
    logic [15:0]      type_sr;
    logic [7:0]       tail_q [0:3];

    t_result due_results [$];
    int      mismatch_n = 0;
    int      result_n   = 0;

    task automatic clear_frame_state();
        pos     = '0;
        pre_ok  = 1'b1;
        addr_ok = 1'b0;
        src_sr  = '0;
        dst_sr  = '0;
        type_sr = '0;
        for (int k = 0; k < 4; k++) tail_q[k] = 8'h00;
    endtask

    // Work out the results one received byte causes and queue them
    task automatic parse_rx_byte(input logic [7:0] b, input logic last);
        t_result     r;
        t_status     st;
        logic [7:0]  leaving;
        int unsigned flen;
        int unsigned plen;
        leaving = tail_q[3];

        // header fields by position
        if (pos < POS_SFD) begin
            if (b != PRE_BYTE) pre_ok = 1'b0;
        end else if (pos == POS_SFD) begin
            if (b != SFD_BYTE) pre_ok = 1'b0;
        end else if (pos < POS_SRC_END) begin
            src_sr = {src_sr[39:0], b};
        end else if (pos < POS_DST_END) begin
            dst_sr = {dst_sr[39:0], b};
            if (pos == POS_DST_LAST) addr_ok = (dst_sr == station_addr);
        end else if (pos < POS_TYPE_END) begin
            type_sr = {type_sr[7:0], b};
        end

        // four-byte delay keeps the CRC out of the payload
        tail_q[3] = tail_q[2];
        tail_q[2] = tail_q[1];
        tail_q[1] = tail_q[0];
        tail_q[0] = b;

        if (pos >= HDR_CRC_LEN && pos < MAX_FRAME_LEN && (pos - HDR_CRC_LEN) < MAX_DATA_LEN &&
            pre_ok && addr_ok) begin
            r = '0;
            r.result_kind         = KIND_PAYLOAD;
            r.last_of_run         = !last;
            r.fields.payload_byte = leaving;
            due_results.push_back(r);
        end

        if (last) begin
            flen = pos + 1;
            if (flen < MIN_FRAME_LEN)
                st = ST_SHORT;
            else if (flen > MAX_FRAME_LEN)
                st = ST_LONG;
            else if (!pre_ok)
                st = ST_BAD_PRE;
            else if (!addr_ok)
                st = ST_ADDR_MISS;
            else
                st = ST_OK;

            if (flen < HDR_CRC_LEN)
                plen = 0;
            else if (flen - HDR_CRC_LEN > MAX_DATA_LEN)
                plen = MAX_DATA_LEN;
            else
                plen = flen - HDR_CRC_LEN;

            r = '0;
            r.result_kind           = KIND_VERDICT;
            r.last_of_run           = 1'b1;
            r.fields.status         = st;
            r.fields.source_mac     = src_sr;
            r.fields.dest_mac       = dst_sr;
            r.fields.frame_type     = type_sr;
            r.fields.payload_length = LEN_W'(plen);
            r.fields.trailer_word   = {tail_q[3], tail_q[2], tail_q[1], tail_q[0]};
            due_results.push_back(r);
            clear_frame_state();
        end else if (pos != POS_MAX) begin
            pos = pos + 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            if (mismatch_n < 10)
                $display("result %0d: %s expected %0h, got %0h", result_n, name, want, got);
            mismatch_n++;
        end
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_result();
        t_result want;
        t_fields got;
        if (due_results.size() == 0) begin
            if (mismatch_n < 10)
                $display("result %0d: no result expected, got kind %0d data %0h",
                         result_n, i_res_tuser, i_res_tdata);
            mismatch_n++;
        end else begin
            want = due_results.pop_front();
            got  = i_res_tdata[FIELDS_W-1:0];
            check_field("result_kind", want.result_kind, i_res_tuser);
            check_field("last_of_run", want.last_of_run, i_res_tlast);
            check_field("payload_byte", want.fields.payload_byte, got.payload_byte);
            check_field("status", want.fields.status, got.status);
            check_field("source_mac", want.fields.source_mac, got.source_mac);
            check_field("dest_mac", want.fields.dest_mac, got.dest_mac);
            check_field("frame_type", want.fields.frame_type, got.frame_type);
            check_field("payload_length", want.fields.payload_length, got.payload_length);
            check_field("trailer_word", want.fields.trailer_word, got.trailer_word);
            check_field("tdata padding", '0, i_res_tdata[167:FIELDS_W]);
        end
        result_n++;
    endtask

    // Requests are taken in order: address write, byte in, result out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            station_addr = '0;
            clear_frame_state();
            due_results.delete();
        end else begin
            if (i_cfg_wr_en) station_addr = i_cfg_wr_data;
            if (i_byte_tvalid && i_byte_tready) parse_rx_byte(i_byte_tdata, i_byte_tlast);
            if (i_res_tvalid && i_res_tready) check_result();
        end
        o_pending    <= due_results.size();
        o_mismatches <= mismatch_n;
    end

endmodule

// ----- tb/sv/ethernet_frame_receive_parser_top_tb.sv -----
// Testbench top for the Ethernet frame receive parser: builds frames, drives
// the byte stream and the station address, and gives the verdict.
// Depends on efrp_pkg, ethernet_frame_receive_parser_top and efrp_rx_checker.
module ethernet_frame_receive_parser_top_tb;
    import efrp_pkg::*;

    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NO_FAULT       = -1;

    logic         i_clk           = 1'b0;
    logic         i_rst_n         = 1'b0;
    logic [7:0]   i_s_axis_tdata  = 8'h00;
    logic         i_s_axis_tlast  = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [167:0] o_m_axis_tdata;
    logic         o_m_axis_tuser;
    logic         o_m_axis_tlast;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic         i_cfg_wr_en     = 1'b0;
    logic [47:0]  i_cfg_wr_data   = '0;

    int          pending;
    int          mismatches;
    int          src_idle_pct = 0;
    int          rx_stall_pct = 0;
    int unsigned bytes_sent   = 0;
    int          quiet_cycles = 0;
    logic [47:0] station_now  = '0;

    ethernet_frame_receive_parser_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    efrp_rx_checker u_rx_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_tdata  (i_s_axis_tdata),
        .i_byte_tlast  (i_s_axis_tlast),
        .i_byte_tvalid (i_s_axis_tvalid),
        .i_byte_tready (o_s_axis_tready),
        .i_res_tdata   (o_m_axis_tdata),
        .i_res_tuser   (o_m_axis_tuser),
        .i_res_tlast   (o_m_axis_tlast),
        .i_res_tvalid  (o_m_axis_tvalid),
        .i_res_tready  (i_m_axis_tready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    // 12-unit clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog: too long without any request
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ethernet_frame_receive_parser_top_tb failed");
            $finish;
        end
    end

    // One byte request, with random gaps ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Frame of flen bytes; bad_at corrupts one byte, noise makes all random
    task automatic send_frame(input int unsigned flen, input logic [47:0] dst,
                              input int bad_at, input bit noise);
        logic [47:0] src;
        logic [7:0]  b;
        src = {16'($urandom), 32'($urandom)};
        for (int unsigned i = 0; i < flen; i++) begin
            if (noise)
                b = 8'($urandom);
            else if (i < 7)
                b = PRE_BYTE;
            else if (i == 7)
                b = SFD_BYTE;
            else if (i < 14)
                b = src[8*(13-i) +: 8];
            else if (i < 20)
                b = dst[8*(19-i) +: 8];
            else
                b = 8'($urandom);
            if (bad_at >= 0 && i == bad_at) b = b ^ 8'($urandom_range(1, 255));
            send_byte(b, i == flen - 1);
        end
        bytes_sent += flen;
    endtask

    // Stop sending and let every outstanding result come out
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_station(input logic [47:0] mac);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mac;
        station_now    = mac;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Mostly well-formed frames, with some broken ones and line noise
    task automatic random_frames(input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        logic [47:0] other;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick  = $urandom_range(99);
            other = {16'($urandom), 32'($urandom)};
            if (pick < 68)
                send_frame($urandom_range(72, 130), station_now, NO_FAULT, 1'b0);
            else if (pick < 76)
                send_frame($urandom_range(72, 100), station_now ^ (other | 48'h1),
                           NO_FAULT, 1'b0);
            else if (pick < 84)
                send_frame($urandom_range(72, 100), pick[0] ? station_now : other,
                           $urandom_range(0, 7), 1'b0);
            else if (pick < 93)
                send_frame($urandom_range(1, 71), station_now, NO_FAULT, 1'b0);
            else
                send_frame($urandom_range(1, 90), other, NO_FAULT, 1'b1);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // receiver stalls more often than not, then the sender idles more often
        src_idle_pct  = 34;
        rx_stall_pct <= 56;
        load_station(48'h0);

        // directed frames
        send_frame(72, 48'h0, NO_FAULT, 1'b0);              // shortest good frame
        send_frame(1, 48'h0, NO_FAULT, 1'b0);               // lone last byte
        send_frame(26, 48'h0, NO_FAULT, 1'b0);              // header and CRC only
        send_frame(71, 48'h0, NO_FAULT, 1'b0);              // one byte short
        send_frame(40, 48'h0, 3, 1'b0);                     // short beats bad preamble
        send_frame(72, 48'h0, 0, 1'b0);                     // bad first preamble byte
        send_frame(80, 48'hFFFF_FFFF_FFFF, 7, 1'b0);        // bad delimiter and address
        send_frame(72, 48'hFFFF_FFFF_FFFF, NO_FAULT, 1'b0); // address mismatch
        random_frames(100);

        src_idle_pct  = 56;
        rx_stall_pct <= 34;
        load_station(48'hFFFF_FFFF_FFFF);
        random_frames(100);

        // full rate both sides
        src_idle_pct  = 0;
        rx_stall_pct <= 0;
        load_station({16'($urandom), 32'($urandom)});
        random_frames(100);

        wait_idle();
        if (mismatches == 0 && pending == 0)
            $display("ethernet_frame_receive_parser_top_tb passed");
        else
            $display("ethernet_frame_receive_parser_top_tb failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/efrp_pkg.sv
src/ethernet_frame_receive_parser_top.sv
tb/sv/efrp_rx_checker.sv
tb/sv/ethernet_frame_receive_parser_top_tb.sv
